FILE: design/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  // Operation codes on the op field
  typedef enum logic [2:0] {
    OPC_ADD = 3'd0,
    OPC_SUB = 3'd1,
    OPC_MUL = 3'd2,
    OPC_DIV = 3'd3,
    OPC_EQ  = 3'd4,
    OPC_LT  = 3'd5
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } status_t;

  // Datapath operations
  typedef enum logic [3:0] {
    AL_NOP, AL_MOV, AL_ONE, AL_ABS, AL_NEG, AL_ADD, AL_SUB, AL_MUL, AL_DIV, AL_REM
  } alu_op_t;

  // Datapath working registers
  typedef enum logic [3:0] {
    R_AP, R_AQ, R_BP, R_BQ, R_P, R_Q, R_X, R_Y, R_L, R_T, R_U
  } reg_sel_t;

  typedef struct packed {
    logic     valid;
    alu_op_t  op;
    reg_sel_t dst;
    reg_sel_t sa;
    reg_sel_t sb;
  } cmd_t;

  typedef struct packed {
    logic       load;
    logic       use_pq;
    logic       cmp;
    logic [1:0] status;
  } out_ctl_t;

  typedef struct packed {
    logic done;
    logic a_zero;
    logic a_neg;
    logic b_zero;
    logic b_neg;
    logic gt_u;
    logic lt_s;
    logic eq;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/rau_datapath.sv
// Datapath: working registers, combinational ALU, shared multiply/divide unit, output register.
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_load,
  input  logic signed [31:0]   a_num,
  input  logic signed [31:0]   a_den,
  input  logic signed [31:0]   b_num,
  input  logic signed [31:0]   b_den,
  input  rau_pkg::cmd_t        cmd,
  input  rau_pkg::out_ctl_t    oc,
  output rau_pkg::dp_status_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   res_num,
  output logic [30:0]          res_den,
  output logic                 compare_true,
  output logic [1:0]           status
);
  import rau_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0] ap, aq, bp, bq, p, q, x, y, l, t, u;
  logic [W-1:0] va, vb, sval, mval, wval, mag_a, mag_b;
  logic [W:0]   r, rs;
  logic [W-1:0] sa, sb;
  logic [CW-1:0] cnt;
  logic busy, fin, qneg, multi, start;

  function automatic logic [W-1:0] rd(input reg_sel_t s);
    logic [W-1:0] v;
    v = '0;
    case (s)
      R_AP: v = ap;
      R_AQ: v = aq;
      R_BP: v = bp;
      R_BQ: v = bq;
      R_P:  v = p;
      R_Q:  v = q;
      R_X:  v = x;
      R_Y:  v = y;
      R_L:  v = l;
      R_T:  v = t;
      R_U:  v = u;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign va = rd(cmd.sa);
  assign vb = rd(cmd.sb);
  assign mag_a = va[W-1] ? (W'(0) - va) : va;
  assign mag_b = vb[W-1] ? (W'(0) - vb) : vb;

  assign multi = (cmd.op == AL_MUL) || (cmd.op == AL_DIV) || (cmd.op == AL_REM);
  assign start = cmd.valid && multi && !busy && !fin;

  // Flags of the selected operands, plus command done and output free
  always_comb begin
    sts.done     = cmd.valid && (multi ? fin : 1'b1);
    sts.a_zero   = (va == '0);
    sts.a_neg    = va[W-1];
    sts.b_zero   = (vb == '0);
    sts.b_neg    = vb[W-1];
    sts.gt_u     = (va > vb);
    sts.lt_s     = ($signed(va) < $signed(vb));
    sts.eq       = (va == vb);
    sts.out_free = !out_valid || !out_stall;
  end

  // Combinational ALU operations
  always_comb begin
    case (cmd.op)
      AL_MOV:  sval = va;
      AL_ONE:  sval = W'(1);
      AL_ABS:  sval = mag_a;
      AL_NEG:  sval = W'(0) - va;
      AL_ADD:  sval = va + vb;
      AL_SUB:  sval = va - vb;
      default: sval = va;
    endcase
  end

  // Multi-cycle results
  always_comb begin
    case (cmd.op)
      AL_MUL:  mval = r[W-1:0];
      AL_DIV:  mval = (sb == '0) ? '0 : (qneg ? (W'(0) - sa) : sa);
      default: mval = r[W-1:0];
    endcase
  end

  assign wval = multi ? mval : sval;
  assign rs = {r[W-1:0], sa[W-1]};

  // Shift-add multiply and restoring divide, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
        r    <= '0;
        if (cmd.op == AL_MUL) begin
          sa <= va;
          sb <= vb;
        end else begin
          sa   <= mag_a;
          sb   <= mag_b;
          qneg <= va[W-1] ^ vb[W-1];
        end
      end else if (busy) begin
        if (cmd.op == AL_MUL) begin
          if (sb[0]) r <= {1'b0, r[W-1:0] + sa};
          sa <= {sa[W-2:0], 1'b0};
          sb <= {1'b0, sb[W-1:1]};
        end else begin
          if (rs >= {1'b0, sb}) begin
            r  <= rs - {1'b0, sb};
            sa <= {sa[W-2:0], 1'b1};
          end else begin
            r  <= rs;
            sa <= {sa[W-2:0], 1'b0};
          end
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Load operands or write back the ALU result
  always_ff @(posedge clk) begin
    if (in_load) begin
      ap <= W'(a_num);
      aq <= W'(a_den);
      bp <= W'(b_num);
      bq <= W'(b_den);
    end else if (sts.done && cmd.op != AL_NOP) begin
      case (cmd.dst)
        R_AP: ap <= wval;
        R_AQ: aq <= wval;
        R_BP: bp <= wval;
        R_BQ: bq <= wval;
        R_P:  p  <= wval;
        R_Q:  q  <= wval;
        R_X:  x  <= wval;
        R_Y:  y  <= wval;
        R_L:  l  <= wval;
        R_T:  t  <= wval;
        R_U:  u  <= wval;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (oc.load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oc.load) begin
      res_num      <= oc.use_pq ? 32'(signed'(p)) : 32'sd0;
      res_den      <= oc.use_pq ? 31'(signed'(q)) : 31'd1;
      compare_true <= oc.cmp;
      status       <= oc.status;
    end
  end

endmodule

FILE: design/rau_controller.sv
// Controller: sequences normalization, GCD, LCM and the operation over the datapath.
`timescale 1ns / 1ps
module rau_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                in_load,
  input  logic [2:0]          op,
  input  rau_pkg::dp_status_t sts,
  output rau_pkg::cmd_t       cmd,
  output rau_pkg::out_ctl_t   oc
);
  import rau_pkg::*;

  localparam int NS = 50;

  typedef enum logic [NS-1:0] {
    S_IDLE   = NS'(1) << 0,  S_N_LD0 = NS'(1) << 1,  S_N_LD1 = NS'(1) << 2,
    S_N_CHK  = NS'(1) << 3,  S_N_ONE = NS'(1) << 4,  S_N_X   = NS'(1) << 5,
    S_N_Y    = NS'(1) << 6,  S_G_ABSX = NS'(1) << 7, S_G_ABSY = NS'(1) << 8,
    S_G_TEST = NS'(1) << 9,  S_G_REMX = NS'(1) << 10, S_G_REMY = NS'(1) << 11,
    S_G_SUM  = NS'(1) << 12, S_N_DP  = NS'(1) << 13, S_N_DQ  = NS'(1) << 14,
    S_N_SGN  = NS'(1) << 15, S_N_ABSP = NS'(1) << 16, S_N_ABSQ = NS'(1) << 17,
    S_N_NEGP = NS'(1) << 18, S_N_DONE = NS'(1) << 19, S_N_ST0 = NS'(1) << 20,
    S_N_ST1  = NS'(1) << 21, S_DISP  = NS'(1) << 22, S_L_X   = NS'(1) << 23,
    S_L_Y    = NS'(1) << 24, S_L_MUL = NS'(1) << 25, S_L_DIV = NS'(1) << 26,
    S_A0     = NS'(1) << 27, S_A1    = NS'(1) << 28, S_A2    = NS'(1) << 29,
    S_A3     = NS'(1) << 30, S_A4    = NS'(1) << 31, S_S0    = NS'(1) << 32,
    S_S1     = NS'(1) << 33, S_S2    = NS'(1) << 34, S_S3    = NS'(1) << 35,
    S_S4     = NS'(1) << 36, S_RES_Q = NS'(1) << 37, S_M0    = NS'(1) << 38,
    S_M1     = NS'(1) << 39, S_D_CHK = NS'(1) << 40, S_D0    = NS'(1) << 41,
    S_D1     = NS'(1) << 42, S_E0    = NS'(1) << 43, S_E1    = NS'(1) << 44,
    S_T0     = NS'(1) << 45, S_T1    = NS'(1) << 46, S_T2    = NS'(1) << 47,
    S_FAIL   = NS'(1) << 48, S_FIN   = NS'(1) << 49
  } state_t;

  // Which fraction the normalize sequence works on
  typedef enum logic [1:0] {NSEL_A, NSEL_B, NSEL_R} nsel_t;

  state_t     state, state_next;
  nsel_t      norm_sel, sel_next;
  logic       gcd_ret, gret_next;
  logic       flip, flip_next;
  logic [1:0] st_r, st_next;
  logic       cmp_r, cmp_next;
  logic       use_pq, pq_next;
  logic [2:0] op_r;

  function automatic cmd_t mk(input alu_op_t o, input reg_sel_t d, input reg_sel_t a,
                              input reg_sel_t b);
    cmd_t c;
    c.valid = 1'b1;
    c.op    = o;
    c.dst   = d;
    c.sa    = a;
    c.sb    = b;
    return c;
  endfunction

  assign in_stall = (state != S_IDLE);

  // Issue at most one command per state and branch on datapath flags
  always_comb begin
    cmd        = '{valid: 1'b0, op: AL_NOP, dst: R_P, sa: R_P, sb: R_P};
    oc         = '0;
    in_load    = 1'b0;
    state_next = state;
    sel_next   = norm_sel;
    gret_next  = gcd_ret;
    flip_next  = flip;
    st_next    = st_r;
    cmp_next   = cmp_r;
    pq_next    = use_pq;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          in_load    = 1'b1;
          sel_next   = NSEL_A;
          st_next    = STAT_OK;
          cmp_next   = 1'b0;
          pq_next    = 1'b0;
          state_next = S_N_LD0;
        end
      end
      S_N_LD0: begin
        cmd = mk(AL_MOV, R_P, (norm_sel == NSEL_A) ? R_AP : R_BP, R_P);
        state_next = S_N_LD1;
      end
      S_N_LD1: begin
        cmd = mk(AL_MOV, R_Q, (norm_sel == NSEL_A) ? R_AQ : R_BQ, R_Q);
        state_next = S_N_CHK;
      end
      S_N_CHK: begin
        cmd = mk(AL_NOP, R_P, R_P, R_Q);
        if (sts.b_zero) state_next = S_FAIL;
        else if (sts.a_zero) state_next = S_N_ONE;
        else state_next = S_N_X;
      end
      S_N_ONE: begin
        cmd = mk(AL_ONE, R_Q, R_Q, R_Q);
        state_next = S_N_DONE;
      end
      S_N_X: begin
        cmd = mk(AL_MOV, R_X, R_P, R_P);
        state_next = S_N_Y;
      end
      S_N_Y: begin
        cmd = mk(AL_MOV, R_Y, R_Q, R_Q);
        gret_next  = 1'b0;
        state_next = S_G_ABSX;
      end
      // Euclidean GCD over X and Y, result left in X
      S_G_ABSX: begin
        cmd = mk(AL_ABS, R_X, R_X, R_X);
        state_next = S_G_ABSY;
      end
      S_G_ABSY: begin
        cmd = mk(AL_ABS, R_Y, R_Y, R_Y);
        state_next = S_G_TEST;
      end
      S_G_TEST: begin
        cmd = mk(AL_NOP, R_X, R_X, R_Y);
        if (sts.a_zero || sts.a_neg || sts.b_zero || sts.b_neg) state_next = S_G_SUM;
        else if (sts.gt_u) state_next = S_G_REMX;
        else state_next = S_G_REMY;
      end
      S_G_REMX: begin
        cmd = mk(AL_REM, R_X, R_X, R_Y);
        state_next = S_G_TEST;
      end
      S_G_REMY: begin
        cmd = mk(AL_REM, R_Y, R_Y, R_X);
        state_next = S_G_TEST;
      end
      S_G_SUM: begin
        cmd = mk(AL_ADD, R_X, R_X, R_Y);
        state_next = gcd_ret ? S_L_DIV : S_N_DP;
      end
      S_N_DP: begin
        cmd = mk(AL_DIV, R_P, R_P, R_X);
        state_next = S_N_DQ;
      end
      S_N_DQ: begin
        cmd = mk(AL_DIV, R_Q, R_Q, R_X);
        state_next = S_N_SGN;
      end
      S_N_SGN: begin
        cmd = mk(AL_NOP, R_P, R_P, R_Q);
        flip_next  = sts.a_neg ^ sts.b_neg;
        state_next = S_N_ABSP;
      end
      S_N_ABSP: begin
        cmd = mk(AL_ABS, R_P, R_P, R_P);
        state_next = S_N_ABSQ;
      end
      S_N_ABSQ: begin
        cmd = mk(AL_ABS, R_Q, R_Q, R_Q);
        state_next = flip ? S_N_NEGP : S_N_DONE;
      end
      S_N_NEGP: begin
        cmd = mk(AL_NEG, R_P, R_P, R_P);
        state_next = S_N_DONE;
      end
      S_N_DONE: begin
        if (norm_sel == NSEL_R) begin
          pq_next    = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_N_ST0;
        end
      end
      S_N_ST0: begin
        cmd = mk(AL_MOV, (norm_sel == NSEL_A) ? R_AP : R_BP, R_P, R_P);
        state_next = S_N_ST1;
      end
      S_N_ST1: begin
        cmd = mk(AL_MOV, (norm_sel == NSEL_A) ? R_AQ : R_BQ, R_Q, R_Q);
        if (norm_sel == NSEL_A) begin
          sel_next   = NSEL_B;
          state_next = S_N_LD0;
        end else begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          OPC_ADD, OPC_SUB: state_next = S_L_X;
          OPC_MUL:          state_next = S_M0;
          OPC_DIV:          state_next = S_D_CHK;
          OPC_EQ:           state_next = S_E0;
          OPC_LT:           state_next = S_T0;
          default:          state_next = S_FIN;
        endcase
      end
      // LCM of the denominators into L
      S_L_X: begin
        cmd = mk(AL_ABS, R_X, R_AQ, R_AQ);
        state_next = S_L_Y;
      end
      S_L_Y: begin
        cmd = mk(AL_ABS, R_Y, R_BQ, R_BQ);
        state_next = S_L_MUL;
      end
      S_L_MUL: begin
        cmd = mk(AL_MUL, R_L, R_X, R_Y);
        gret_next  = 1'b1;
        state_next = S_G_ABSX;
      end
      S_L_DIV: begin
        cmd = mk(AL_DIV, R_L, R_L, R_X);
        state_next = (op_r == OPC_ADD) ? S_A0 : S_S0;
      end
      S_A0: begin cmd = mk(AL_MUL, R_T, R_AP, R_L); state_next = S_A1; end
      S_A1: begin cmd = mk(AL_DIV, R_T, R_T, R_AQ); state_next = S_A2; end
      S_A2: begin cmd = mk(AL_MUL, R_U, R_BP, R_L); state_next = S_A3; end
      S_A3: begin cmd = mk(AL_DIV, R_U, R_U, R_BQ); state_next = S_A4; end
      S_A4: begin cmd = mk(AL_ADD, R_P, R_T, R_U);  state_next = S_RES_Q; end
      S_S0: begin cmd = mk(AL_DIV, R_T, R_L, R_AQ); state_next = S_S1; end
      S_S1: begin cmd = mk(AL_MUL, R_T, R_AP, R_T); state_next = S_S2; end
      S_S2: begin cmd = mk(AL_DIV, R_U, R_L, R_BQ); state_next = S_S3; end
      S_S3: begin cmd = mk(AL_MUL, R_U, R_BP, R_U); state_next = S_S4; end
      S_S4: begin cmd = mk(AL_SUB, R_P, R_T, R_U);  state_next = S_RES_Q; end
      S_RES_Q: begin
        cmd = mk(AL_MOV, R_Q, R_L, R_L);
        sel_next   = NSEL_R;
        state_next = S_N_CHK;
      end
      S_M0: begin cmd = mk(AL_MUL, R_P, R_AP, R_BP); state_next = S_M1; end
      S_M1: begin
        cmd = mk(AL_MUL, R_Q, R_AQ, R_BQ);
        sel_next   = NSEL_R;
        state_next = S_N_CHK;
      end
      S_D_CHK: begin
        cmd = mk(AL_NOP, R_BP, R_BP, R_BP);
        if (sts.a_zero) begin
          st_next    = STAT_DIV_ZERO;
          state_next = S_FIN;
        end else begin
          state_next = S_D0;
        end
      end
      S_D0: begin cmd = mk(AL_MUL, R_P, R_AP, R_BQ); state_next = S_D1; end
      S_D1: begin
        cmd = mk(AL_MUL, R_Q, R_AQ, R_BP);
        sel_next   = NSEL_R;
        state_next = S_N_CHK;
      end
      S_E0: begin
        cmd = mk(AL_NOP, R_AP, R_AP, R_BP);
        state_next = sts.eq ? S_E1 : S_FIN;
      end
      S_E1: begin
        cmd = mk(AL_NOP, R_AQ, R_AQ, R_BQ);
        cmp_next   = sts.eq;
        state_next = S_FIN;
      end
      S_T0: begin cmd = mk(AL_MUL, R_T, R_AP, R_BQ); state_next = S_T1; end
      S_T1: begin cmd = mk(AL_MUL, R_U, R_BP, R_AQ); state_next = S_T2; end
      S_T2: begin
        cmd = mk(AL_NOP, R_T, R_T, R_U);
        cmp_next   = sts.lt_s;
        state_next = S_FIN;
      end
      S_FAIL: begin
        st_next    = STAT_ZERO_DEN;
        pq_next    = 1'b0;
        cmp_next   = 1'b0;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          oc.load    = 1'b1;
          oc.use_pq  = use_pq;
          oc.cmp     = cmp_r;
          oc.status  = st_r;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Hold while a multi-cycle command is still running
    if (cmd.valid && !sts.done) begin
      state_next = state;
      sel_next   = norm_sel;
      gret_next  = gcd_ret;
      flip_next  = flip;
      st_next    = st_r;
      cmp_next   = cmp_r;
      pq_next    = use_pq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      norm_sel <= NSEL_A;
      gcd_ret  <= 1'b0;
      flip     <= 1'b0;
      st_r     <= STAT_OK;
      cmp_r    <= 1'b0;
      use_pq   <= 1'b0;
    end else begin
      state    <= state_next;
      norm_sel <= sel_next;
      gcd_ret  <= gret_next;
      flip     <= flip_next;
      st_r     <= st_next;
      cmp_r    <= cmp_next;
      use_pq   <= pq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) op_r <= op;
  end

endmodule

FILE: design/rational_arithmetic_unit_core.sv
// Processing time is data dependent; a zero left denominator ends the item before any
// multiply or divide. Each multiply, divide or modulo runs on one shared shift-add /
// restoring divide unit, plus one compare per GCD step; up to four GCD loops and twelve
// more multiplies and divides per item set the processing time. One item is in work
// at a time; a new beat is taken while the previous result waits in the output
// register.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               compare_true,
  output logic [1:0]         status
);
  import rau_pkg::*;

  cmd_t       cmd;
  out_ctl_t   oc;
  dp_status_t sts;
  logic       in_load;

  rau_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_load  (in_load),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd),
    .oc       (oc)
  );

  rau_datapath #(.W(DATA_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_load      (in_load),
    .a_num        (a_num),
    .a_den        (a_den),
    .b_num        (b_num),
    .b_den        (b_den),
    .cmd          (cmd),
    .oc           (oc),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res_num      (res_num),
    .res_den      (res_den),
    .compare_true (compare_true),
    .status       (status)
  );

endmodule

FILE: design/rau_checker.sv
// Port-level checks on the result channel of the rational arithmetic unit.
`timescale 1ns / 1ps
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] res_num,
  input logic [30:0]        res_den,
  input logic               compare_true,
  input logic [1:0]         status
);
  import rau_pkg::*;

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den)
      && $stable(compare_true) && $stable(status))
    else $error("stalled result beat changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_ZERO_DEN || status == STAT_DIV_ZERO)
    else $error("undefined status code");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> res_num == 0 && res_den == 31'd1 && !compare_true)
    else $error("error beat carries a value");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> status == STAT_OK && res_num == 0 && res_den == 31'd1)
    else $error("comparison beat carries a fraction");

endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (.*);
